### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the solver.
// Needs a clock named clock and a reset named reset in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition never holds
`define ASSERT_NEVER(label, cond, msg) \
   `ASSERT_CLK(label, !(cond), msg)

`endif

### rtl/core/tts_pkg.sv
// Shared types, constants and helpers of the tridiagonal solver.
// No dependencies; used by the solver top level, its divider and checker.
package tts_pkg;

   localparam int MAX_NODES = 64;
   localparam int WORD_BITS = 32;
   localparam int IDX_BITS  = $clog2(MAX_NODES);
   localparam int FRAC_BITS = 16;
   localparam int PROD_BITS = 2 * WORD_BITS;
   // intermediate numerator and denominator: product above the fraction plus one bit
   localparam int ACC_BITS  = PROD_BITS - FRAC_BITS + 1;
   // quotient magnitude bits computed before saturation
   localparam int QUO_BITS  = WORD_BITS + 1;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [ACC_BITS-1:0]  acc_type;
   typedef logic signed [PROD_BITS-1:0] prod_type;
   typedef logic [IDX_BITS-1:0]         idx_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   typedef struct packed {
      word_type coef_east;
      word_type coef_west;
      word_type coef_center;
      word_type source_term;
      logic     last_node;
   } req_type;

   typedef struct packed {
      word_type solution;
      idx_type  node_index;
      logic     div_error;
      logic     last_result;
   } rsp_type;

   typedef struct packed {
      logic    start;
      acc_type num;
      acc_type den;
   } div_req_type;

   typedef struct packed {
      logic     done;
      logic     zero;
      word_type quot;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_MUL_Q,
      ST_SUM,
      ST_DIVP_GO,
      ST_DIVP_WAIT,
      ST_DIVQ_GO,
      ST_DIVQ_WAIT,
      ST_EMIT,
      ST_BS_MUL,
      ST_BS_ADD
   } state_type;

   // Clamp a wide signed value into one word
   function automatic word_type sat_word(acc_type v);
      word_type r;
      if (v > acc_type'(WORD_MAX)) begin
         r = WORD_MAX;
      end else if (v < acc_type'(WORD_MIN)) begin
         r = WORD_MIN;
      end else begin
         r = word_type'(v);
      end
      return r;
   endfunction

endpackage

### rtl/core/tts_divider.sv
// Bit-serial restoring divider: saturated Q16.16 quotient of num * 2^16 / den.
// Depends on tts_pkg; one quotient bit per cycle after a wide overflow check.
module tts_divider (
   input  logic                clock,
   input  logic                reset,
   input  tts_pkg::div_req_type div_req,
   output tts_pkg::div_rsp_type div_rsp
);

   localparam int REM_BITS = tts_pkg::ACC_BITS + 1;
   localparam int CNT_BITS = $clog2(tts_pkg::QUO_BITS + 1);

   logic                                busy_ff, busy_in;
   logic [CNT_BITS-1:0]                 cnt_ff, cnt_in;
   logic [REM_BITS-1:0]                 rem_ff, rem_in;
   logic [tts_pkg::QUO_BITS-1:0]        sh_ff, sh_in;
   logic [tts_pkg::QUO_BITS-1:0]        q_ff, q_in;
   logic [tts_pkg::ACC_BITS-1:0]        ad_ff, ad_in;
   logic                                neg_ff, neg_in;
   tts_pkg::div_rsp_type                rsp_ff, rsp_in;

   logic [tts_pkg::ACC_BITS-1:0]        an;
   logic [tts_pkg::ACC_BITS-1:0]        ad;
   logic [tts_pkg::ACC_BITS-1:0]        high;
   logic [REM_BITS-1:0]                 trial;
   logic [tts_pkg::QUO_BITS-1:0]        q_next;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      q_in    = q_ff;
      ad_in   = ad_ff;
      neg_in  = neg_ff;
      rsp_in  = rsp_ff;
      rsp_in.done = 1'b0;

      // magnitudes of the operands
      an   = div_req.num[tts_pkg::ACC_BITS-1] ? tts_pkg::ACC_BITS'(-div_req.num)
                                               : tts_pkg::ACC_BITS'(div_req.num);
      ad   = div_req.den[tts_pkg::ACC_BITS-1] ? tts_pkg::ACC_BITS'(-div_req.den)
                                               : tts_pkg::ACC_BITS'(div_req.den);
      // dividend bits above the computed quotient range
      high = an >> (tts_pkg::QUO_BITS - tts_pkg::FRAC_BITS);

      trial  = {rem_ff[REM_BITS-2:0], sh_ff[tts_pkg::QUO_BITS-1]};
      q_next = {q_ff[tts_pkg::QUO_BITS-2:0], 1'b0};

      if (div_req.start) begin
         // classify the request, then start the bit loop
         neg_in = div_req.num[tts_pkg::ACC_BITS-1] ^ div_req.den[tts_pkg::ACC_BITS-1];
         if (div_req.den == '0) begin
            rsp_in.done = 1'b1;
            rsp_in.zero = 1'b1;
            rsp_in.quot = div_req.num[tts_pkg::ACC_BITS-1] ? tts_pkg::WORD_MIN
                                                           : tts_pkg::WORD_MAX;
         end else if (high >= ad) begin
            rsp_in.done = 1'b1;
            rsp_in.zero = 1'b0;
            rsp_in.quot = (div_req.num[tts_pkg::ACC_BITS-1] ^
                           div_req.den[tts_pkg::ACC_BITS-1]) ? tts_pkg::WORD_MIN
                                                              : tts_pkg::WORD_MAX;
         end else begin
            busy_in = 1'b1;
            cnt_in  = CNT_BITS'(tts_pkg::QUO_BITS);
            rem_in  = REM_BITS'(high);
            sh_in   = {an[tts_pkg::QUO_BITS-tts_pkg::FRAC_BITS-1:0],
                       {tts_pkg::FRAC_BITS{1'b0}}};
            q_in    = '0;
            ad_in   = ad;
         end
      end else if (busy_ff) begin
         // shift one dividend bit in and subtract where it fits
         sh_in = {sh_ff[tts_pkg::QUO_BITS-2:0], 1'b0};
         if (trial >= REM_BITS'(ad_ff)) begin
            rem_in = trial - REM_BITS'(ad_ff);
            q_next[0] = 1'b1;
         end else begin
            rem_in = trial;
         end
         q_in   = q_next;
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in     = 1'b0;
            rsp_in.done = 1'b1;
            rsp_in.zero = 1'b0;
            if (neg_ff) begin
               if (q_next > {1'b0, tts_pkg::WORD_MIN}) begin
                  rsp_in.quot = tts_pkg::WORD_MIN;
               end else begin
                  rsp_in.quot = tts_pkg::WORD_BITS'(-q_next);
               end
            end else if (q_next > {1'b0, tts_pkg::WORD_MAX}) begin
               rsp_in.quot = tts_pkg::WORD_MAX;
            end else begin
               rsp_in.quot = tts_pkg::WORD_BITS'(q_next);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         cnt_ff      <= '0;
         rsp_ff.done <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         cnt_ff      <= cnt_in;
         rsp_ff.done <= rsp_in.done;
      end
      rem_ff      <= rem_in;
      sh_ff       <= sh_in;
      q_ff        <= q_in;
      ad_ff       <= ad_in;
      neg_ff      <= neg_in;
      rsp_ff.zero <= rsp_in.zero;
      rsp_ff.quot <= rsp_in.quot;
   end

   assign div_rsp = rsp_ff;

endmodule

### rtl/core/tridiagonal_thomas_solver.sv
// Thomas-algorithm tridiagonal solver, signed Q16.16, one node per request.
// Forward node: three multiply and sum steps, then two divisions (ratio and offset);
// a division with a zero divisor or an overflow caught by the wide check skips the bit loop.
// Closing node: one division to the first solution, then a multiply and an add step per
// further node plus the wait on rsp_stall; one shared 32x32 multiplier, one divider.
// Synchronous active-high reset clears the sequencer, node count, error flag and output valid.
module tridiagonal_thomas_solver (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tts_pkg::rsp_type rsp_data
);

   tts_pkg::state_type   state_ff, state_in;
   tts_pkg::idx_type     count_ff, count_in;
   logic                 err_ff, err_in;
   tts_pkg::word_type    ae_ff, ae_in, aw_ff, aw_in, ap_ff, ap_in, b_ff, b_in;
   logic                 last_ff, last_in;
   tts_pkg::prod_type    prod_ff, prod_in;
   tts_pkg::acc_type     d_ff, d_in, n_ff, n_in;
   tts_pkg::word_type    x_ff, x_in;
   tts_pkg::idx_type     k_ff, k_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   tts_pkg::rsp_type     rsp_ff, rsp_in;

   // node stores, one write and one read port each
   tts_pkg::word_type    ratio_mem  [tts_pkg::MAX_NODES];
   tts_pkg::word_type    offset_mem [tts_pkg::MAX_NODES];
   tts_pkg::word_type    rp_ff, rq_ff;
   logic                 rd_en;
   tts_pkg::idx_type     rd_addr;
   logic                 wr_p_en, wr_q_en;
   tts_pkg::idx_type     wr_addr;
   tts_pkg::word_type    wr_p_data, wr_q_data;

   tts_pkg::word_type    mul_a, mul_b;
   tts_pkg::prod_type    mul_out;
   tts_pkg::acc_type     prod_hi;
   tts_pkg::div_req_type div_req;
   tts_pkg::div_rsp_type div_rsp;

   tts_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // shared multiplier and the floor of its fraction shift
   assign mul_out = tts_pkg::prod_type'(mul_a) * tts_pkg::prod_type'(mul_b);
   assign prod_hi = tts_pkg::ACC_BITS'(prod_ff >>> tts_pkg::FRAC_BITS);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      err_in       = err_ff;
      ae_in        = ae_ff;
      aw_in        = aw_ff;
      ap_in        = ap_ff;
      b_in         = b_ff;
      last_in      = last_ff;
      prod_in      = prod_ff;
      d_in         = d_ff;
      n_in         = n_ff;
      x_in         = x_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      req_stall    = (state_ff != tts_pkg::ST_IDLE);
      rd_en        = 1'b0;
      rd_addr      = count_ff - tts_pkg::IDX_BITS'(1);
      wr_p_en      = 1'b0;
      wr_q_en      = 1'b0;
      wr_addr      = count_ff;
      wr_p_data    = div_rsp.quot;
      wr_q_data    = div_rsp.quot;
      mul_a        = aw_ff;
      mul_b        = rp_ff;
      div_req.start = 1'b0;
      div_req.num   = n_ff;
      div_req.den   = d_ff;

      case (state_ff)
         tts_pkg::ST_IDLE: begin
            // take a node and fetch the previous node's ratio and offset
            if (req_valid) begin
               ae_in    = req_data.coef_east;
               aw_in    = req_data.coef_west;
               ap_in    = req_data.coef_center;
               b_in     = req_data.source_term;
               last_in  = req_data.last_node ||
                          (count_ff == tts_pkg::IDX_BITS'(tts_pkg::MAX_NODES - 1));
               rd_en    = 1'b1;
               state_in = tts_pkg::ST_MUL_P;
            end
         end
         tts_pkg::ST_MUL_P: begin
            // west term of the denominator; the first node has none
            mul_a    = (count_ff == '0) ? '0 : aw_ff;
            mul_b    = (count_ff == '0) ? '0 : rp_ff;
            prod_in  = mul_out;
            state_in = tts_pkg::ST_MUL_Q;
         end
         tts_pkg::ST_MUL_Q: begin
            d_in     = tts_pkg::acc_type'(ap_ff) - prod_hi;
            mul_a    = (count_ff == '0) ? '0 : aw_ff;
            mul_b    = (count_ff == '0) ? '0 : rq_ff;
            prod_in  = mul_out;
            state_in = tts_pkg::ST_SUM;
         end
         tts_pkg::ST_SUM: begin
            n_in = prod_hi + tts_pkg::acc_type'(b_ff);
            if (last_ff) begin
               // the closing node has no east neighbor
               wr_p_en   = 1'b1;
               wr_p_data = '0;
               state_in  = tts_pkg::ST_DIVQ_GO;
            end else begin
               state_in  = tts_pkg::ST_DIVP_GO;
            end
         end
         tts_pkg::ST_DIVP_GO: begin
            div_req.start = 1'b1;
            div_req.num   = tts_pkg::acc_type'(ae_ff);
            state_in      = tts_pkg::ST_DIVP_WAIT;
         end
         tts_pkg::ST_DIVP_WAIT: begin
            if (div_rsp.done) begin
               wr_p_en  = 1'b1;
               err_in   = err_ff | div_rsp.zero;
               state_in = tts_pkg::ST_DIVQ_GO;
            end
         end
         tts_pkg::ST_DIVQ_GO: begin
            div_req.start = 1'b1;
            state_in      = tts_pkg::ST_DIVQ_WAIT;
         end
         tts_pkg::ST_DIVQ_WAIT: begin
            if (div_rsp.done) begin
               wr_q_en = 1'b1;
               err_in  = err_ff | div_rsp.zero;
               if (last_ff) begin
                  // start back substitution at the closing node
                  x_in               = div_rsp.quot;
                  k_in               = count_ff;
                  rsp_valid_in       = 1'b1;
                  rsp_in.solution    = div_rsp.quot;
                  rsp_in.node_index  = count_ff;
                  rsp_in.div_error   = err_ff | div_rsp.zero;
                  rsp_in.last_result = (count_ff == '0);
                  state_in           = tts_pkg::ST_EMIT;
               end else begin
                  count_in = count_ff + tts_pkg::IDX_BITS'(1);
                  state_in = tts_pkg::ST_IDLE;
               end
            end
         end
         tts_pkg::ST_EMIT: begin
            // hold the solution until taken, then step one node down or, after node zero, return to idle
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (k_ff == '0) begin
                  count_in = '0;
                  err_in   = 1'b0;
                  state_in = tts_pkg::ST_IDLE;
               end else begin
                  k_in     = k_ff - tts_pkg::IDX_BITS'(1);
                  rd_en    = 1'b1;
                  rd_addr  = k_ff - tts_pkg::IDX_BITS'(1);
                  state_in = tts_pkg::ST_BS_MUL;
               end
            end
         end
         tts_pkg::ST_BS_MUL: begin
            mul_a    = rp_ff;
            mul_b    = x_ff;
            prod_in  = mul_out;
            state_in = tts_pkg::ST_BS_ADD;
         end
         tts_pkg::ST_BS_ADD: begin
            x_in               = tts_pkg::sat_word(prod_hi + tts_pkg::acc_type'(rq_ff));
            rsp_valid_in       = 1'b1;
            rsp_in.solution    = tts_pkg::sat_word(prod_hi + tts_pkg::acc_type'(rq_ff));
            rsp_in.node_index  = k_ff;
            rsp_in.div_error   = err_ff;
            rsp_in.last_result = (k_ff == '0);
            state_in           = tts_pkg::ST_EMIT;
         end
         default: begin
            state_in = tts_pkg::ST_IDLE;
         end
      endcase
   end

   // sequencer and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tts_pkg::ST_IDLE;
         count_ff     <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ae_ff   <= ae_in;
      aw_ff   <= aw_in;
      ap_ff   <= ap_in;
      b_ff    <= b_in;
      last_ff <= last_in;
      prod_ff <= prod_in;
      d_ff    <= d_in;
      n_ff    <= n_in;
      x_ff    <= x_in;
      k_ff    <= k_in;
      rsp_ff  <= rsp_in;
   end

   // node stores with registered read
   always_ff @(posedge clock) begin
      if (wr_p_en) begin
         ratio_mem[wr_addr] <= wr_p_data;
      end
      if (wr_q_en) begin
         offset_mem[wr_addr] <= wr_q_data;
      end
      if (rd_en) begin
         rp_ff <= ratio_mem[rd_addr];
         rq_ff <= offset_mem[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/core/tts_checker.sv
// Port-level checks of the tridiagonal solver, bound to its top level.
// Depends on tts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tts_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input tts_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input tts_pkg::rsp_type rsp_data
);

   // a stalled solution holds its value
   `ASSERT_CLK(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)), "stalled solution changed")

   // no request is taken while a solution is pending
   `ASSERT_NEVER(a_busy_out, rsp_valid && !req_stall, "request open while solution pending")

   // an accepted request closes the input for the next cycle
   `ASSERT_CLK(a_req_busy, (req_valid && !req_stall) |=> req_stall, "input open after request")

   // the final solution belongs to node zero
   `ASSERT_CLK(a_last_idx, (rsp_valid && rsp_data.last_result) |-> (rsp_data.node_index == '0), "final solution not node zero")

   // solutions are spaced by the multiply and add steps
   `ASSERT_CLK(a_rsp_gap, (rsp_valid && !rsp_stall) |=> !rsp_valid, "solutions back to back")

endmodule

bind tridiagonal_thomas_solver tts_checker u_tts_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

### sim/tridiagonal_thomas_solver_test.sv
// Testbench for the tridiagonal Thomas solver: drives node coefficients, predicts
// the back-substituted solutions and checks them in order. Depends on tts_pkg.
`timescale 1ns / 1ps

class solution_board;
   tts_pkg::rsp_type pending[$];
   int failures;
   logic signed [63:0] ratio_mem[tts_pkg::MAX_NODES];
   logic signed [63:0] offset_mem[tts_pkg::MAX_NODES];
   int node_cnt;
   bit err_seen;

   function new();
      failures = 0;
      node_cnt = 0;
      err_seen = 0;
   endfunction

   // floor division by 2^16 (arithmetic shift floors)
   function logic signed [127:0] fl16(logic signed [127:0] v);
      return v >>> 16;
   endfunction

   function logic signed [63:0] clamp(logic signed [127:0] v);
      if (v > 128'sd2147483647) return 64'sd2147483647;
      if (v < -128'sd2147483648) return -64'sd2147483648;
      return v[63:0];
   endfunction

   function logic signed [63:0] qdiv(logic signed [127:0] num, logic signed [127:0] den);
      logic signed [127:0] q;
      if (den == 0) begin
         err_seen = 1;
         return (num < 0) ? -64'sd2147483648 : 64'sd2147483647;
      end
      q = (num * 128'sd65536) / den;
      return clamp(q);
   endfunction

   // Advance the forward sweep; emit solutions on the closing node
   function void note_request(tts_pkg::req_type r);
      logic signed [127:0] ae, aw, ap, b, pp, qp, d, n, x;
      int i;
      bit last;
      tts_pkg::rsp_type e;
      ae = r.coef_east; aw = r.coef_west; ap = r.coef_center; b = r.source_term;
      last = r.last_node;
      i = node_cnt;
      pp = 0; qp = 0;
      if (i >= tts_pkg::MAX_NODES - 1) begin
         i = tts_pkg::MAX_NODES - 1;
         last = 1;
      end
      if (i == 0) begin
         aw = 0;
      end else begin
         pp = ratio_mem[i-1];
         qp = offset_mem[i-1];
      end
      d = ap - fl16(aw * pp);
      n = fl16(aw * qp) + b;
      if (!last) begin
         ratio_mem[i] = qdiv(ae, d);
         offset_mem[i] = qdiv(n, d);
         node_cnt = i + 1;
         return;
      end
      ratio_mem[i] = 0;
      offset_mem[i] = qdiv(n, d);
      x = offset_mem[i];
      for (int k = i; k >= 0; k--) begin
         if (k != i) x = clamp(fl16(ratio_mem[k] * x) + offset_mem[k]);
         e.solution = x[31:0];
         e.node_index = k[5:0];
         e.div_error = err_seen;
         e.last_result = (k == 0);
         pending.push_back(e);
      end
      node_cnt = 0;
      err_seen = 0;
   endfunction

   // Compare one solution with the oldest expected one
   function void check_solution(tts_pkg::rsp_type got);
      tts_pkg::rsp_type e;
      if (pending.size() == 0) begin
         $display("%0t unexpected solution %h", $realtime, got);
         failures++;
         return;
      end
      e = pending.pop_front();
      if (got !== e) begin
         $display({"%0t mismatch: expected sol=%h idx=%0d err=%b last=%b, ",
                   "actual sol=%h idx=%0d err=%b last=%b"},
            $realtime, e.solution, e.node_index, e.div_error, e.last_result,
            got.solution, got.node_index, got.div_error, got.last_result);
         failures++;
      end
   endfunction
endclass

module tridiagonal_thomas_solver_test;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   tts_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1;
   tts_pkg::rsp_type rsp_data;

   int send_idle = 27;
   int recv_idle = 84;
   int hold_cycles = 0;
   solution_board board;

   tridiagonal_thomas_solver uut (.*);

   always #1 clock = ~clock;

   // Random coefficient with frequent extremes and small values
   function automatic tts_pkg::word_type pick_word();
      case ($urandom_range(0, 9))
         0: return tts_pkg::WORD_MAX;
         1: return tts_pkg::WORD_MIN;
         2: return 0;
         3, 4: return tts_pkg::word_type'($urandom);
         default: return tts_pkg::word_type'($urandom_range(0, 32'h60000)) - 32'sh30000;
      endcase
   endfunction

   // Diagonal value, mostly dominant so systems stay well conditioned
   function automatic tts_pkg::word_type pick_center();
      if ($urandom_range(0, 19) == 0) return 0;
      if ($urandom_range(0, 9) == 0) return pick_word();
      return ($urandom_range(0, 1) ? 1 : -1) *
             tts_pkg::word_type'($urandom_range(32'h40000, 32'h100000));
   endfunction

   // Offer one request and hold it until accepted
   task automatic send_node(tts_pkg::word_type ae, tts_pkg::word_type aw,
                            tts_pkg::word_type ap, tts_pkg::word_type b, logic last);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= '{ae, aw, ap, b, last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request('{ae, aw, ap, b, last});
   endtask

   task automatic send_system(int len);
      for (int i = 0; i < len; i++)
         send_node(pick_word(), pick_word(), pick_center(), pick_word(), i == len - 1);
   endtask

   // Drop valid and wait for every expected solution plus drain time
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // Receiver: random stall, or a long hold when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1;
      end else begin
         if (rsp_valid && !rsp_stall) board.check_solution(rsp_data);
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle);
         end
      end
   end

   initial begin
      int sent;
      board = new();
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: single nodes, short systems, extremes, zero pivot, ignored west/east
      send_node(0, tts_pkg::WORD_MAX, 32'sh10000, 32'sh30000, 1);
      send_node(tts_pkg::WORD_MAX, tts_pkg::WORD_MIN, tts_pkg::WORD_MIN,
                tts_pkg::WORD_MAX, 1);
      send_node(0, 0, 0, 32'sh10000, 1);
      send_node(0, 0, 0, -32'sh10000, 1);
      send_node(0, 0, 0, 0, 1);
      send_node(tts_pkg::WORD_MIN, 0, 32'sh20000, tts_pkg::WORD_MIN, 1);
      send_node(-32'sh10000, tts_pkg::WORD_MAX, 32'sh40000, 32'sh10000, 0);
      send_node(-32'sh10000, -32'sh10000, 32'sh40000, 32'sh20000, 0);
      send_node(tts_pkg::WORD_MAX, -32'sh10000, 32'sh40000, 32'sh30000, 1);
      send_node(32'sh10000, 0, 32'sh10000, 0, 0);
      send_node(0, 32'sh10000, 32'sh10000, 32'sh10000, 1);
      send_node(tts_pkg::WORD_MAX, tts_pkg::WORD_MAX, tts_pkg::WORD_MAX,
                tts_pkg::WORD_MAX, 0);
      send_node(tts_pkg::WORD_MIN, tts_pkg::WORD_MIN, tts_pkg::WORD_MIN,
                tts_pkg::WORD_MIN, 1);
      // Overflow: 64 nodes without last_node, forced close at the end
      for (int i = 0; i < 64; i++)
         send_node(pick_word(), pick_word(), pick_center(), pick_word(), 0);
      drain();
      // Long receiver hold while the sender keeps offering
      hold_cycles = 3000;
      send_system(6);
      send_system(4);
      drain();
      sent = 0;
      for (int ph = 0; ph < 3; ph++) begin
         if (ph == 1) begin send_idle = 84; recv_idle = 27; end
         if (ph == 2) begin send_idle = 0; recv_idle = 0; end
         while (sent < (ph + 1) * 105) begin
            int len;
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 8);
            send_system(len);
            sent += len;
         end
         drain();
      end
      if (board.failures == 0 && board.pending.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Global timeout
   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end
endmodule

### tridiagonal_thomas_solver.f
+incdir+rtl/core
rtl/core/tts_pkg.sv
rtl/core/tts_divider.sv
rtl/core/tridiagonal_thomas_solver.sv
rtl/core/tts_checker.sv
sim/tridiagonal_thomas_solver_test.sv
